FILE: rtl/sglr_pkg.sv
// Package: shared types and constants for the SGD linear regression update core.
`timescale 1ns / 1ps
`default_nettype none
package sglr_pkg;
    localparam int unsigned FEATURE_FIELDS = 8;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned ERR_W = 63;
    localparam int unsigned IDX_W = 4;
    localparam int unsigned RATE_W = 16;
    localparam int unsigned CNT_W = 4;
    localparam int unsigned EPS_W = 32;
    // rounded products and the residual sum are carried at this width
    localparam int unsigned SUM_W = 64;
    localparam logic [1:0] REG_RATE = 2'd0;
    localparam logic [1:0] REG_COUNT = 2'd1;
    localparam logic [1:0] REG_EPS = 2'd2;

    typedef struct packed {
        logic signed [DATA_W-1:0] feature_1;
        logic signed [DATA_W-1:0] feature_2;
        logic signed [DATA_W-1:0] feature_3;
        logic signed [DATA_W-1:0] feature_4;
        logic signed [DATA_W-1:0] feature_5;
        logic signed [DATA_W-1:0] feature_6;
        logic signed [DATA_W-1:0] feature_7;
        logic signed [DATA_W-1:0] feature_8;
        logic signed [DATA_W-1:0] target_y;
    } t_sample;

    typedef struct packed {
        logic [IDX_W-1:0]         weight_index;
        logic signed [DATA_W-1:0] weight_value;
        logic [ERR_W-1:0]         sample_error;
        logic                     converged;
        logic                     last_of_run;
    } t_result;

    typedef struct packed {
        logic [1:0]        index;
        logic [EPS_W-1:0]  data;
    } t_cfg;

    // lane control: which phase the lanes compute
    typedef struct packed {
        logic                     upd;   // 1: weight update, 0: product
        logic signed [DATA_W-1:0] grad;
    } t_lane_ctl;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) return 32'sh7fffffff;
        if (v < -66'sd2147483648) return 32'sh80000000;
        return v[DATA_W-1:0];
    endfunction
endpackage
`default_nettype wire

FILE: rtl/sglr_if.sv
// Interface: valid/ready channel carrying one payload word.
`timescale 1ns / 1ps
`default_nettype none
interface sglr_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/sglr_lane.sv
// Lane: one weight, forms its rounded product and its update, registered.
`timescale 1ns / 1ps
`default_nettype none
module sglr_lane
    import sglr_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_en,
    input  wire                      i_used,
    input  t_lane_ctl                i_ctl,
    input  wire signed [DATA_W-1:0]  i_x,
    input  wire signed [DATA_W-1:0]  i_w,
    output logic signed [SUM_W-1:0]  o_prod,
    output logic signed [DATA_W-1:0] o_w_new
);
    logic signed [DATA_W-1:0] w_mul;
    logic signed [63:0]       prod;
    logic signed [64:0]       rnd;
    logic signed [SUM_W-1:0]  r_prod;
    logic signed [DATA_W-1:0] r_w_new;

    // one shared 32x32 multiplier: weight*x or grad*x
    assign w_mul = i_ctl.upd ? i_ctl.grad : i_w;
    assign prod  = w_mul * i_x;
    assign rnd   = ($signed({prod[63], prod}) + (65'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod  <= '0;
            r_w_new <= '0;
        end else if (i_en) begin
            if (!i_used) begin
                r_prod  <= '0;
                r_w_new <= i_w;
            end else if (i_ctl.upd) begin
                r_w_new <= sat32(66'(i_w) + 66'(rnd));
            end else begin
                // |w*x| <= 2^62 so the rounded value fits in 64 bits
                r_prod <= rnd[SUM_W-1:0];
            end
        end
    end
    assign o_prod  = r_prod;
    assign o_w_new = r_w_new;
endmodule
`default_nettype wire

FILE: rtl/sglr_merge.sv
// Merge: adder tree over lane products, residual against target.
`timescale 1ns / 1ps
`default_nettype none
module sglr_merge
    import sglr_pkg::*;
#(
    parameter int LANES = 8
) (
    input  wire                     i_clk,
    input  wire                     i_en,
    input  wire signed [SUM_W-1:0]  i_prod [LANES],
    input  wire signed [DATA_W-1:0] i_y,
    input  wire signed [DATA_W-1:0] i_w0,
    output logic signed [SUM_W-1:0] o_res
);
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] r_res;
    always_comb begin
        sum = SUM_W'(i_y) - SUM_W'(i_w0);
        for (int i = 0; i < LANES; i++) sum = sum - i_prod[i];
    end
    always_ff @(posedge i_clk) begin
        if (i_en) r_res <= sum;
    end
    assign o_res = r_res;
endmodule
`default_nettype wire

FILE: rtl/sgd_linear_regression_update_core.sv
// Top level: SGD linear regression update with parallel weight lanes.
// One sample is taken in, then up to eight lanes form all weight*feature products
// at once, an adder stage merges them into the residual, the step is scaled
// by the learning rate, the lanes apply the update, and the products under the
// new weights are merged again to give the squared error. After the accept
// cycle a sample runs its compute steps in order (lane product pass, merge,
// residual clamp, gradient multiply, gradient round, lane update pass, weight
// write-back, second lane product pass, second merge, square prep, square,
// error compare) and then gives n+1 output words, one per cycle when the sink
// is ready, where n is the feature count in use; the next sample is taken once
// the last word leaves. Reset holds no sweep: weights and the previous error
// clear at once.
`timescale 1ns / 1ps
`default_nettype none
module sgd_linear_regression_update_core
    import sglr_pkg::*;
#(
    parameter int MAX_FEATURES = 8,
    parameter int FRAC_BITS = 16
) (
    input wire i_clk,
    input wire i_rst_n,
    sglr_if.sink   s_in,
    sglr_if.source m_out,
    sglr_if.sink   s_cfg
);
    localparam int LIM = (MAX_FEATURES < FEATURE_FIELDS) ? MAX_FEATURES : FEATURE_FIELDS;

    typedef enum logic [3:0] {
        S_IDLE, S_P1, S_M1, S_G1, S_G2, S_G3, S_U, S_WB, S_P2, S_M2, S_SQ, S_CMP,
        S_CNV, S_OUT
    } t_state;
    t_state r_state;

    logic signed [DATA_W-1:0] r_w [MAX_FEATURES+1];
    logic signed [DATA_W-1:0] r_x [LIM];
    logic signed [DATA_W-1:0] r_y;
    logic [RATE_W-1:0] r_rate;
    logic [CNT_W-1:0]  r_count, r_n;
    logic [EPS_W-1:0]  r_eps;
    logic [63:0]       r_prev, r_err;
    logic              r_conv;
    logic signed [DATA_W-1:0] r_rsat, r_g;
    logic signed [49:0] r_gp;
    logic [CNT_W-1:0]  r_oidx;
    logic [DATA_W-1:0] r_mag;
    logic              r_big;

    logic lane_en;
    t_lane_ctl ctl;
    logic signed [SUM_W-1:0]  prod [LIM];
    logic signed [DATA_W-1:0] wnew [LIM];
    logic signed [SUM_W-1:0]  res;

    assign ctl.upd  = (r_state == S_U);
    assign ctl.grad = r_g;
    assign lane_en  = (r_state == S_P1) || (r_state == S_U) || (r_state == S_P2);

    for (genvar l = 0; l < LIM; l++) begin : g_lane
        sglr_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(lane_en),
            .i_used(CNT_W'(l) < r_n), .i_ctl(ctl), .i_x(r_x[l]), .i_w(r_w[l+1]),
            .o_prod(prod[l]), .o_w_new(wnew[l])
        );
    end

    sglr_merge #(.LANES(LIM)) u_merge (
        .i_clk(i_clk), .i_en((r_state == S_M1) || (r_state == S_M2)),
        .i_prod(prod), .i_y(r_y), .i_w0(r_w[0]), .o_res(res)
    );

    assign s_in.ready  = (r_state == S_IDLE);
    assign s_cfg.ready = (r_state == S_IDLE);
    assign m_out.valid = (r_state == S_OUT);
    assign m_out.data.weight_index = r_oidx;
    assign m_out.data.weight_value = r_w[r_oidx];
    assign m_out.data.sample_error = r_err[ERR_W-1:0];
    assign m_out.data.converged    = r_conv;
    assign m_out.data.last_of_run  = (r_oidx == r_n);

    logic [63:0] chg;
    assign chg = (r_err >= r_prev) ? r_err - r_prev : r_prev - r_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rate  <= RATE_W'(655);
            r_count <= CNT_W'(8);
            r_eps   <= '0;
            r_prev  <= '0;
            r_oidx  <= '0;
            for (int i = 0; i <= MAX_FEATURES; i++) r_w[i] <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (s_cfg.valid) begin
                        case (s_cfg.data.index)
                            REG_RATE:  r_rate  <= s_cfg.data.data[RATE_W-1:0];
                            REG_COUNT: r_count <= s_cfg.data.data[CNT_W-1:0];
                            REG_EPS:   r_eps   <= s_cfg.data.data;
                            default: ;
                        endcase
                    end
                    if (s_in.valid) begin
                        r_x[0] <= s_in.data.feature_1;
                        if (LIM > 1) r_x[1 % LIM] <= s_in.data.feature_2;
                        if (LIM > 2) r_x[2 % LIM] <= s_in.data.feature_3;
                        if (LIM > 3) r_x[3 % LIM] <= s_in.data.feature_4;
                        if (LIM > 4) r_x[4 % LIM] <= s_in.data.feature_5;
                        if (LIM > 5) r_x[5 % LIM] <= s_in.data.feature_6;
                        if (LIM > 6) r_x[6 % LIM] <= s_in.data.feature_7;
                        if (LIM > 7) r_x[7 % LIM] <= s_in.data.feature_8;
                        r_y <= s_in.data.target_y;
                        r_n <= (r_count > CNT_W'(LIM)) ? CNT_W'(LIM) : r_count;
                        r_state <= S_P1;
                    end
                end
                S_P1: r_state <= S_M1;
                S_M1: r_state <= S_G1;
                S_G1: begin
                    r_rsat  <= sat32(66'(res));
                    r_state <= S_G2;
                end
                S_G2: begin
                    r_gp    <= 50'(signed'({1'b0, r_rate})) * 50'(r_rsat) * 50'sd2;
                    r_state <= S_G3;
                end
                S_G3: begin
                    r_g     <= sat32(66'((r_gp + 50'sd32768) >>> 16));
                    r_state <= S_U;
                end
                S_U: begin
                    // lanes form their new weights from g this cycle
                    r_w[0]  <= sat32(66'(r_w[0]) + 66'(r_g));
                    r_state <= S_WB;
                end
                S_WB: begin
                    for (int i = 0; i < LIM; i++) r_w[i+1] <= wnew[i];
                    r_state <= S_P2;
                end
                S_P2: r_state <= S_M2;
                S_M2: r_state <= S_SQ;
                S_SQ: begin
                    r_mag   <= res[SUM_W-1] ? 32'(-res) : 32'(res);
                    r_big   <= (res[SUM_W-1] ? -res : res) > 64'sd3037000499;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_err   <= r_big ? 64'h7fffffffffffffff : 64'(r_mag) * 64'(r_mag);
                    r_state <= S_CNV;
                end
                S_CNV: begin
                    r_conv  <= (chg <= 64'(r_eps));
                    r_prev  <= r_err;
                    r_oidx  <= '0;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (m_out.ready) begin
                        if (r_oidx == r_n) r_state <= S_IDLE;
                        r_oidx <= r_oidx + CNT_W'(1);
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: rtl/sglr_checker.sv
// Checker: port-level properties of the core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module sglr_checker
    import sglr_pkg::*;
(
    input wire i_clk,
    input wire i_rst_n,
    input wire in_v, input wire in_r,
    input wire out_v, input wire out_r,
    input t_result out_d
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_v && !out_r |=> out_v && $stable(out_d)) else $error("output word changed");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(in_r && out_v)) else $error("input taken during output");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_v && in_r |=> !in_r) else $error("second word taken while busy");
    a_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(out_v) |-> out_d.weight_index == '0) else $error("run not from bias");
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_v && out_r && out_d.last_of_run |=> !out_v) else $error("word after last");
endmodule
bind sgd_linear_regression_update_core sglr_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .in_v(s_in.valid), .in_r(s_in.ready),
    .out_v(m_out.valid), .out_r(m_out.ready), .out_d(m_out.data)
);
`default_nettype wire

FILE: bench/sgd_linear_regression_update_core_test.sv
// Testbench: SGD linear regression update core checked against a bit-true predictor.
`timescale 1ns / 1ps
`default_nettype none
module sgd_linear_regression_update_core_test;
    import sglr_pkg::*;

    localparam longint WMAX = 64'sd2147483647;
    localparam longint WMIN = -64'sd2147483648;
    localparam longint unsigned ERR_CAP = 64'h7fff_ffff_ffff_ffff;
    localparam longint unsigned ROOT_CAP = 64'd3037000499;

    class sgd_scoreboard;
        longint weights [9];
        longint unsigned last_error;
        longint rate;
        int unsigned feat_count;
        longint unsigned epsilon;
        t_result pending [$];
        int errors;

        function new();
            foreach (weights[i]) weights[i] = 0;
            last_error = 0;
            rate = 655;
            feat_count = 8;
            epsilon = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] v);
            case (idx)
                REG_RATE: rate = v[15:0];
                REG_COUNT: feat_count = v[3:0];
                REG_EPS: epsilon = v;
                default: ;
            endcase
        endfunction

        // round half up, dropping s fraction bits
        function longint rnd(longint v, int s);
            return (v + (longint'(1) << (s - 1))) >>> s;
        endfunction

        function longint clip(longint v);
            if (v > WMAX) return WMAX;
            if (v < WMIN) return WMIN;
            return v;
        endfunction

        function longint residual(longint x [8], longint y, int n);
            longint r;
            r = y - weights[0];
            for (int i = 1; i <= n; i++) r -= rnd(weights[i] * x[i-1], 16);
            return r;
        endfunction

        function void note_sample(t_sample s);
            longint x [8];
            longint y, r, g, rn;
            longint unsigned mag, err, chg;
            int n;
            t_result e;
            x[0] = s.feature_1; x[1] = s.feature_2; x[2] = s.feature_3;
            x[3] = s.feature_4; x[4] = s.feature_5; x[5] = s.feature_6;
            x[6] = s.feature_7; x[7] = s.feature_8;
            y = s.target_y;
            n = feat_count > 8 ? 8 : feat_count;
            r = clip(residual(x, y, n));
            g = clip(rnd(2 * rate * r, 16));
            weights[0] = clip(weights[0] + g);
            for (int i = 1; i <= n; i++)
                weights[i] = clip(weights[i] + rnd(g * x[i-1], 16));
            rn = residual(x, y, n);
            mag = rn < 0 ? -rn : rn;
            err = mag > ROOT_CAP ? ERR_CAP : mag * mag;
            chg = err >= last_error ? err - last_error : last_error - err;
            last_error = err;
            for (int i = 0; i <= n; i++) begin
                e.weight_index = 4'(i);
                e.weight_value = weights[i][31:0];
                e.sample_error = err[62:0];
                e.converged = chg <= epsilon;
                e.last_of_run = i == n;
                pending.push_back(e);
            end
        endfunction

        function void check_result(t_result a);
            t_result e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word, got %h", $time, a);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.weight_index !== e.weight_index) begin
                $display("%0t: weight_index exp %0d got %0d", $time, e.weight_index,
                         a.weight_index);
                errors++;
            end
            if (a.weight_value !== e.weight_value) begin
                $display("%0t: weight_value exp %h got %h", $time, e.weight_value,
                         a.weight_value);
                errors++;
            end
            if (a.sample_error !== e.sample_error) begin
                $display("%0t: sample_error exp %h got %h", $time, e.sample_error,
                         a.sample_error);
                errors++;
            end
            if (a.converged !== e.converged) begin
                $display("%0t: converged exp %b got %b", $time, e.converged, a.converged);
                errors++;
            end
            if (a.last_of_run !== e.last_of_run) begin
                $display("%0t: last_of_run exp %b got %b", $time, e.last_of_run,
                         a.last_of_run);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit calm;
    sgd_scoreboard sb;

    sglr_if #(.T(t_sample)) in_if ();
    sglr_if #(.T(t_result)) out_if ();
    sglr_if #(.T(t_cfg))    cfg_if ();

    sgd_linear_regression_update_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_in    (in_if),
        .m_out   (out_if),
        .s_cfg   (cfg_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

    // result side: stall at random, check on handshake
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_if.ready = calm || $urandom_range(99) >= 19;
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready) sb.check_result(out_if.data);
        end
    end

    task automatic send_sample(t_sample s);
        while (!calm && $urandom_range(99) < 19) begin
            in_if.valid = 1'b0;
            @(negedge i_clk);
        end
        in_if.valid = 1'b1;
        in_if.data = s;
        forever begin
            @(posedge i_clk);
            if (in_if.ready) break;
        end
        sb.note_sample(s);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] v);
        in_if.valid = 1'b0;
        cfg_if.valid = 1'b1;
        cfg_if.data.index = idx;
        cfg_if.data.data = v;
        forever begin
            @(posedge i_clk);
            if (cfg_if.ready) break;
        end
        sb.set_reg(idx, v);
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    // hold off until every word is back, then let the core settle
    task automatic drain();
        in_if.valid = 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (12) @(negedge i_clk);
    endtask

    function automatic t_sample make_sample(logic signed [31:0] f, logic signed [31:0] y);
        t_sample s;
        s = {f, f, f, f, f, f, f, f, y};
        return s;
    endfunction

    function automatic logic signed [31:0] near();
        return $signed($urandom_range(524288)) - 32'sd262144;
    endfunction

    function automatic t_sample rand_sample();
        t_sample s;
        if ($urandom_range(9) == 0) begin
            s = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom};
        end else begin
            s = {near(), near(), near(), near(), near(), near(), near(), near(),
                 near() * 4};
        end
        return s;
    endfunction

    initial begin
        sb = new();
        calm = 1'b0;
        in_if.valid = 1'b0;
        in_if.data = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data = '0;
        i_rst_n = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // reset settings: first sample, extremes of the fields
        send_sample(make_sample(32'sd0, 32'sd0));
        send_sample(make_sample(32'sd65536, 32'sd131072));
        send_sample(make_sample(32'sh7fffffff, 32'sh7fffffff));
        send_sample(make_sample(32'sh80000000, 32'sh80000000));
        send_sample(make_sample(32'sh7fffffff, 32'sh80000000));
        send_sample(make_sample(-32'sd65536, 32'sd65536));
        drain();
        write_reg(REG_RATE, 32'hffff);
        write_reg(REG_EPS, 32'hffffffff);
        send_sample(make_sample(32'sd65536, 32'sd327680));
        send_sample(make_sample(32'sh80000000, 32'sh7fffffff));
        drain();
        write_reg(REG_COUNT, 32'd0);
        send_sample(make_sample(32'sd65536, 32'sd65536));
        send_sample(make_sample(32'sd0, -32'sd65536));
        drain();
        write_reg(REG_COUNT, 32'd1);
        send_sample(make_sample(32'sd131072, 32'sd65536));
        drain();
        write_reg(REG_COUNT, 32'd15);
        write_reg(REG_RATE, 32'd0);
        send_sample(make_sample(32'sd65536, 32'sd65536));
        drain();
        write_reg(REG_COUNT, 32'd9);
        write_reg(REG_EPS, 32'd0);
        write_reg(REG_RATE, 32'd655);
        send_sample(make_sample(32'sd32768, 32'sd98304));
        drain();
        write_reg(REG_COUNT, 32'd3);
        send_sample(make_sample(32'sd65536, 32'sd196608));
        send_sample(make_sample(-32'sd65536, 32'sd196608));

        for (int phase = 0; phase < 5; phase++) begin
            drain();
            write_reg(REG_RATE, phase == 0 ? 32'hffff : phase == 1 ? 32'd0 : $urandom_range(6000));
            write_reg(REG_COUNT, phase == 3 ? 32'd8 : $urandom_range(15));
            write_reg(REG_EPS, phase == 4 ? 32'hffffffff : $urandom_range(3) == 0 ? $urandom : 0);
            calm = phase == 2;
            for (int k = 0; k < 50; k++) send_sample(rand_sample());
            calm = 1'b0;
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire
